### rtl/core/tdcits_pkg.sv
package tdcits_pkg;

	localparam int CHANNELS = 2;
	localparam int CH_W = $clog2(CHANNELS);
	localparam logic [CH_W-1:0] CH_A_IDX = CH_W'(0);
	localparam logic [CH_W-1:0] CH_B_IDX = CH_W'(1);

	// Both queue depths are powers of two so the pointers wrap by themselves.
	localparam int CMD_DEPTH = 2;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 30;
	localparam logic [CFG_INDEX_W-1:0] CFG_RESULT_MODE = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_COARSE_TICK = CFG_INDEX_W'(1);

	localparam logic [29:0] TICK_RESET = 30'd100000000;

	// One second in ps, and its split around bit 32: 232 * 2^32 + 3567587328.
	localparam logic [39:0] PS_IN_SECOND = 40'd1000000000000;
	localparam logic [31:0] PS_IN_SECOND_LO = 32'd3567587328;
	localparam logic [7:0] PS_IN_SECOND_HI = 8'd232;

	localparam logic [2:0] KIND_STAMP = 3'd0;
	localparam logic [2:0] KIND_INTERVAL = 3'd1;
	localparam logic [2:0] KIND_PERIOD = 3'd2;
	localparam logic [2:0] KIND_CH_A = 3'd3;
	localparam logic [2:0] KIND_CH_B = 3'd4;
	localparam logic [2:0] KIND_CH_C = 3'd5;
	localparam logic [2:0] KIND_LOST = 3'd6;
	localparam logic [2:0] KIND_RESTORED = 3'd7;

	typedef enum logic [1:0] {
		REQ_COARSE,
		REQ_STOP,
		REQ_FINE,
		REQ_CHECK
	} req_t;

	typedef enum logic [1:0] {
		MODE_STAMP,
		MODE_A_TO_B,
		MODE_CYCLE,
		MODE_TRIPLE
	} mode_t;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_MUL,
		EX_CALC,
		EX_UPD,
		EX_ADDC,
		EX_EMIT
	} exec_state_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        channel;
		logic [33:0] fine_time_ps;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         result_kind;
		logic               result_channel;
		logic signed [63:0] value_ps;
		logic               last_of_run;
	} out_item_t;

	typedef struct packed {
		req_t            op;
		logic [CH_W-1:0] channel;
		logic [33:0]     fine_ps;
	} cmd_t;

endpackage

### rtl/core/tdcits_front.sv
module tdcits_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  tdcits_pkg::in_item_t in_item,
	output logic                 cmd_valid,
	input  logic                 cmd_take,
	output tdcits_pkg::cmd_t     cmd
);
	import tdcits_pkg::*;

	cmd_t                 slot_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_PTR_W:0]   cnt_q;
	logic                 wr_go;
	logic                 rd_go;
	cmd_t                 cmd_in;

	assign full = (cnt_q == (CMD_PTR_W+1)'(CMD_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign wr_go = push && !full;
	assign rd_go = cmd_take && cmd_valid;
	assign cmd = slot_q[rd_ptr_q];

	always_comb begin
		cmd_in.op = req_t'(in_item.req_type);
		cmd_in.channel = CH_W'(in_item.channel);
		cmd_in.fine_ps = in_item.fine_time_ps;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_go) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_go) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_go && !rd_go) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_go && !wr_go) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_go) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

### rtl/core/tdcits_exec.sv
module tdcits_exec (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_wr_en,
	input  logic [tdcits_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [tdcits_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                     cmd_valid,
	output logic                                     cmd_take,
	input  tdcits_pkg::cmd_t                         cmd,
	input  logic                                     res_full,
	output logic                                     res_push,
	output tdcits_pkg::out_item_t                    res_item
);
	import tdcits_pkg::*;

	exec_state_t st_q;
	exec_state_t st_d;

	mode_t       mode_q;
	logic [29:0] tick_q;

	logic [63:0] coarse_q;
	logic [63:0] seen_q;
	logic        lost_q;
	logic [63:0] cap_q    [CHANNELS];
	logic [63:0] now_q    [CHANNELS];
	logic [31:0] hit_q    [CHANNELS];
	logic        valid_q  [CHANNELS];

	logic [CH_W-1:0] ch_q;
	logic [33:0]     fine_q;
	logic [61:0]     plo_q;
	logic [31:0]     phi_q;
	logic [63:0]     hlo_q;
	logic [31:0]     hhi_q;
	logic [63:0]     stamp_q;
	logic [63:0]     hterm_q;
	out_item_t       res_q [3];
	logic [1:0]      idx_q;
	logic [1:0]      last_q;

	logic        chk_same;
	logic        chk_lost;
	logic        chk_restore;
	logic        upd_emit;
	logic [63:0] cap_sel;
	logic [63:0] stamp_a;
	logic [63:0] stamp_b;
	logic [63:0] diff;
	logic [63:0] period;

	assign chk_same = (coarse_q == seen_q);
	assign chk_lost = chk_same && !lost_q;
	assign chk_restore = !chk_same && lost_q;
	assign cap_sel = cap_q[ch_q];

	assign stamp_a = (ch_q == CH_A_IDX) ? stamp_q : now_q[CH_A_IDX];
	assign stamp_b = (ch_q == CH_B_IDX) ? stamp_q : now_q[CH_B_IDX];
	assign diff = stamp_b - stamp_a;
	assign period = stamp_q - now_q[ch_q];

	// Own channel turns valid in this update, so pairing needs only the other one.
	assign upd_emit = (hit_q[ch_q] > 32'd2) &&
		(mode_q == MODE_STAMP || mode_q == MODE_CYCLE || valid_q[~ch_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= EX_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		cmd_take = 1'b0;
		res_push = 1'b0;
		res_item = res_q[idx_q];
		unique case (st_q)
			EX_IDLE: begin
				cmd_take = cmd_valid;
				if (cmd_valid) begin
					unique case (cmd.op)
						REQ_COARSE, REQ_STOP: begin
							st_d = EX_IDLE;
						end
						REQ_FINE: begin
							if (!lost_q) begin
								st_d = EX_MUL;
							end
						end
						REQ_CHECK: begin
							if (chk_lost || chk_restore) begin
								st_d = EX_EMIT;
							end
						end
					endcase
				end
			end
			EX_MUL: st_d = EX_CALC;
			EX_CALC: st_d = EX_UPD;
			EX_UPD: begin
				if (!upd_emit) begin
					st_d = EX_IDLE;
				end else if (mode_q == MODE_TRIPLE) begin
					st_d = EX_ADDC;
				end else begin
					st_d = EX_EMIT;
				end
			end
			EX_ADDC: st_d = EX_EMIT;
			EX_EMIT: begin
				res_push = !res_full;
				if (!res_full && idx_q == last_q) begin
					st_d = EX_IDLE;
				end
			end
			default: st_d = EX_IDLE;
		endcase
	end

	// Configuration and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STAMP;
			tick_q <= TICK_RESET;
			coarse_q <= '0;
			seen_q <= '0;
			lost_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				cap_q[i] <= '0;
				now_q[i] <= '0;
				hit_q[i] <= '0;
				valid_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_RESULT_MODE: mode_q <= mode_t'(cfg_data[1:0]);
					CFG_COARSE_TICK: tick_q <= cfg_data;
				endcase
			end

			if (st_q == EX_IDLE && cmd_valid) begin
				unique case (cmd.op)
					REQ_COARSE: coarse_q <= coarse_q + 64'd1;
					REQ_STOP: cap_q[cmd.channel] <= coarse_q;
					REQ_FINE: ;
					REQ_CHECK: begin
						if (chk_lost) begin
							lost_q <= 1'b1;
						end
						if (!chk_same) begin
							seen_q <= coarse_q;
						end
						if (chk_restore) begin
							lost_q <= 1'b0;
							for (int i = 0; i < CHANNELS; i++) begin
								cap_q[i] <= '0;
								now_q[i] <= '0;
								hit_q[i] <= '0;
								valid_q[i] <= 1'b0;
							end
						end
					end
				endcase
			end

			if (st_q == EX_MUL) begin
				hit_q[ch_q] <= hit_q[ch_q] + 32'd1;
			end

			if (st_q == EX_UPD) begin
				// Paired results consume both timestamps.
				if (upd_emit && (mode_q == MODE_A_TO_B || mode_q == MODE_TRIPLE)) begin
					for (int i = 0; i < CHANNELS; i++) begin
						now_q[i] <= '0;
						valid_q[i] <= 1'b0;
					end
				end else begin
					now_q[ch_q] <= stamp_q;
					valid_q[ch_q] <= 1'b1;
				end
			end
		end
	end

	// Work registers of the fine-result sequence and the result buffer.
	always_ff @(posedge clk) begin
		unique case (st_q)
			EX_IDLE: begin
				ch_q <= cmd.channel;
				fine_q <= cmd.fine_ps;
				idx_q <= '0;
				last_q <= '0;
				if (chk_lost) begin
					res_q[0] <= '{KIND_LOST, 1'b0, 64'sd0, 1'b1};
				end else begin
					res_q[0] <= '{KIND_RESTORED, 1'b0, 64'sd0, 1'b1};
				end
			end
			EX_MUL: begin
				plo_q <= 62'(cap_sel[31:0]) * 62'(tick_q);
				phi_q <= 32'(cap_sel[63:32] * 32'(tick_q));
				hlo_q <= 64'(hit_q[CH_B_IDX]) * 64'(PS_IN_SECOND_LO);
				hhi_q <= 32'(hit_q[CH_B_IDX] * 32'(PS_IN_SECOND_HI));
			end
			EX_CALC: begin
				stamp_q <= 64'(plo_q) + {phi_q, 32'd0} - 64'(fine_q);
				// hit_count[B] * 1e12 - 1, with the pending increment folded in.
				hterm_q <= hlo_q + {hhi_q, 32'd0}
					+ ((ch_q == CH_B_IDX) ? 64'(PS_IN_SECOND) : 64'd0) - 64'd1;
			end
			EX_UPD: begin
				unique case (mode_q)
					MODE_STAMP: begin
						res_q[0] <= '{KIND_STAMP, ch_q, stamp_q, 1'b1};
						last_q <= 2'd0;
					end
					MODE_CYCLE: begin
						res_q[0] <= '{KIND_PERIOD, ch_q, period, 1'b1};
						last_q <= 2'd0;
					end
					MODE_A_TO_B: begin
						res_q[0] <= '{KIND_INTERVAL, ch_q, diff, 1'b1};
						last_q <= 2'd0;
					end
					MODE_TRIPLE: begin
						res_q[0] <= '{KIND_CH_A, 1'b0, stamp_a, 1'b0};
						res_q[1] <= '{KIND_CH_B, 1'b1, stamp_b, 1'b0};
						res_q[2] <= '{KIND_CH_C, ch_q, diff, 1'b1};
						last_q <= 2'd2;
					end
				endcase
			end
			EX_ADDC: begin
				res_q[2].value_ps <= res_q[2].value_ps + hterm_q;
			end
			EX_EMIT: begin
				if (!res_full) begin
					idx_q <= idx_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

endmodule

### rtl/core/tdcits_resq.sv
module tdcits_resq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  res_push,
	output logic                  res_full,
	input  tdcits_pkg::out_item_t res_item,
	output logic                  empty,
	input  logic                  pop,
	output tdcits_pkg::out_item_t out_item
);
	import tdcits_pkg::*;

	out_item_t            slot_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q;
	logic [RES_PTR_W-1:0] rd_ptr_q;
	logic [RES_PTR_W:0]   cnt_q;
	logic                 wr_go;
	logic                 rd_go;

	assign res_full = (cnt_q == (RES_PTR_W+1)'(RES_DEPTH));
	assign empty = (cnt_q == '0);
	assign wr_go = res_push && !res_full;
	assign rd_go = pop && !empty;
	assign out_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_go) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_go) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_go && !rd_go) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_go && !wr_go) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_go) begin
			slot_q[wr_ptr_q] <= res_item;
		end
	end

endmodule

### rtl/core/tdc_interpolated_timestamp_counter_top.sv
// Channel   Direction  Handshake            Payload
// input     in         push / full          in_item  (req_type, channel, fine_time_ps)
// result    out        empty / pop          out_item (result_kind, result_channel,
//                                                     value_ps, last_of_run)
// config    in         cfg_wr_en            cfg_index, cfg_data
//
// Coarse ticks and stop edges are taken in the executor's idle state; a fine result
// steps through EX_MUL, EX_CALC and EX_UPD, then EX_ADDC for the three-word set and
// EX_EMIT, set by the two-step 64 x 30 timestamp multiply and the 64-bit add chain behind it.
// A two-entry command queue keeps taking items while the executor works,
// and a four-entry result queue decouples the executor from pop.
// Reset is asynchronous and leaves both queues empty and all counts at zero.
module tdc_interpolated_timestamp_counter_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  tdcits_pkg::in_item_t               in_item,
	output logic                               empty,
	input  logic                               pop,
	output tdcits_pkg::out_item_t              out_item,
	input  logic                               cfg_wr_en,
	input  logic [tdcits_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tdcits_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tdcits_pkg::*;

	logic      cmd_valid;
	logic      cmd_take;
	cmd_t      cmd;
	logic      res_full;
	logic      res_push;
	out_item_t res_item;

	tdcits_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_item   (in_item),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd)
	);

	tdcits_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_item  (res_item)
	);

	tdcits_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_full (res_full),
		.res_item (res_item),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item)
	);

endmodule

### rtl/core/tdcits_checker.sv
module tdcits_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  full,
	input logic                  empty,
	input logic                  pop,
	input tdcits_pkg::out_item_t out_item
);
	import tdcits_pkg::*;

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> empty && !full)
		else $error("queues not empty under reset");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_item))
		else $error("waiting result changed before transfer");

	a_supervision_value: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (out_item.result_kind == KIND_LOST || out_item.result_kind == KIND_RESTORED)
		|-> out_item.value_ps == 64'sd0 && !out_item.result_channel && out_item.last_of_run)
		else $error("clock supervision result carries data");

	a_last_marking: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> out_item.last_of_run ==
		!(out_item.result_kind == KIND_CH_A || out_item.result_kind == KIND_CH_B))
		else $error("last_of_run wrong for result kind");

endmodule

bind tdc_interpolated_timestamp_counter_top tdcits_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.out_item (out_item)
);
